### sv/sha256_stream_hasher_unit_assert.svh
// ---------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shorthand for clocked assertions, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sha256sh_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher package
// Command and status types, round constants and the round functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256sh_pkg;

  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  typedef struct packed {
    logic       push;
    src_t       src;
    logic       load_v;
    logic       round;
    logic [5:0] rnd;
    logic       add;
    logic       out_shift;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
  } sts_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

### sv/sha256sh_ctrl.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher controller
// Sequences byte intake, padding, compression rounds and digest output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256sh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  input  logic                byte_present,
  input  logic                end_of_message,
  input  logic                dig_stall,
  input  sha256sh_pkg::sts_t  sts,
  output logic                msg_stall,
  output logic                dig_valid,
  output logic [2:0]          word_index,
  output logic                last_word,
  output sha256sh_pkg::cmd_t  cmd
);
  import sha256sh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_ZERO,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t     state;
  state_t     ret;
  logic [5:0] rnd;
  logic [2:0] out_idx;
  logic       last;
  logic       in_acc;
  logic       out_acc;

  assign msg_stall  = (state != ST_IDLE);
  assign dig_valid  = (state == ST_OUT);
  assign word_index = out_idx;
  assign last_word  = last;
  assign in_acc     = msg_valid & ~msg_stall;
  assign out_acc    = dig_valid & ~dig_stall;

  always_comb begin
    cmd           = '0;
    cmd.src       = SRC_MSG;
    cmd.rnd       = rnd;
    cmd.out_idx   = out_idx;
    unique case (state)
      ST_IDLE: begin
        cmd.push = in_acc & byte_present;
      end
      ST_PAD80: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_PAD;
      end
      ST_ZERO: begin
        cmd.push = ~sts.fill_at_len;
        cmd.src  = SRC_ZERO;
      end
      ST_LEN: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_LEN;
      end
      ST_COMP: cmd.round = 1'b1;
      ST_ADD:  cmd.add = 1'b1;
      ST_OUT:  cmd.out_shift = out_acc;
      default: cmd.push = 1'b0;
    endcase
    cmd.load_v = cmd.push & sts.fill_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ret     <= ST_IDLE;
      rnd     <= '0;
      out_idx <= '0;
      last    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (byte_present && sts.fill_last) begin
              state <= ST_COMP;
              ret   <= end_of_message ? ST_PAD80 : ST_IDLE;
              rnd   <= '0;
            end else if (end_of_message) begin
              state <= ST_PAD80;
            end
          end
        end
        ST_PAD80: begin
          if (sts.fill_last) begin
            state <= ST_COMP;
            ret   <= ST_ZERO;
            rnd   <= '0;
          end else begin
            state <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (sts.fill_at_len) begin
            state <= ST_LEN;
          end else if (sts.fill_last) begin
            state <= ST_COMP;
            ret   <= ST_ZERO;
            rnd   <= '0;
          end
        end
        ST_LEN: begin
          if (sts.fill_last) begin
            state <= ST_COMP;
            ret   <= ST_OUT;
            rnd   <= '0;
          end
        end
        ST_COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == BLOCK_LAST) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          state   <= ret;
          out_idx <= '0;
          last    <= 1'b0;
        end
        ST_OUT: begin
          if (out_acc) begin
            out_idx <= out_idx + 3'd1;
            last    <= (out_idx == 3'd6);
            if (last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### sv/sha256sh_dp.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher datapath
// Block words with sliding schedule, round registers, chain words, length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256sh_dp (
  input  logic                clk,
  input  logic                rst,
  input  sha256sh_pkg::cmd_t  cmd,
  input  logic [7:0]          msg_byte,
  output sha256sh_pkg::sts_t  sts,
  output logic [31:0]         digest_word
);
  import sha256sh_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [7:0]  push_byte;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] w_new;

  assign sts.fill_last   = (fill == BLOCK_LAST);
  assign sts.fill_at_len = (fill == LEN_POS);
  assign digest_word     = h[0];

  always_comb begin
    unique case (cmd.src)
      SRC_MSG:  push_byte = msg_byte;
      SRC_PAD:  push_byte = PAD_BYTE;
      SRC_ZERO: push_byte = 8'h00;
      SRC_LEN:  push_byte = bit_len[63:56];
      default:  push_byte = 8'h00;
    endcase
  end

  always_comb begin
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + big_sigma1(v[4]) + ch + ROUND_K[cmd.rnd] + w[0];
    t2    = big_sigma0(v[0]) + maj;
    w_new = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];
  end

  // block words and working variables
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= push_byte;
    end
    if (cmd.load_v) begin
      v <= h;
    end
    if (cmd.round) begin
      for (int k = 0; k < 15; k++) begin
        w[k] <= w[k + 1];
      end
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // chain words, fill count, length
  always_ff @(posedge clk) begin
    if (rst) begin
      h       <= INIT_H;
      fill    <= '0;
      bit_len <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
        if (cmd.src == SRC_MSG) begin
          bit_len <= bit_len + 64'd8;
        end else if (cmd.src == SRC_LEN) begin
          bit_len <= {bit_len[55:0], 8'h00};
        end
      end
      if (cmd.add) begin
        for (int k = 0; k < 8; k++) begin
          h[k] <= h[k] + v[k];
        end
      end
      // digest leaves from h[0]; initial values refill from the top
      if (cmd.out_shift) begin
        for (int k = 0; k < 7; k++) begin
          h[k] <= h[k + 1];
        end
        h[7] <= INIT_H[cmd.out_idx];
      end
    end
  end

endmodule

### sv/sha256_stream_hasher_unit.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide streaming SHA-256 with padding and an eight-word digest output.
// ---------------------------------------------------------------------------
// A byte word is taken while msg_stall is low. The byte that completes a
// 64-byte block is followed by msg_stall high for 64 compression rounds, one
// per cycle through a single round unit, and then the chain update. An
// end-of-message word then brings the pad and length bytes (9 to 72 bytes),
// one or two further compressions, and eight digest words, H0 first, each
// held while dig_stall is high. No input word is taken while padding,
// compressing or emitting the digest.
`timescale 1ns / 1ps

module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256sh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sha256sh_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .dig_stall      (dig_stall),
    .sts            (sts),
    .msg_stall      (msg_stall),
    .dig_valid      (dig_valid),
    .word_index     (word_index),
    .last_word      (last_word),
    .cmd            (cmd)
  );

  sha256sh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_byte    (msg_byte),
    .sts         (sts),
    .digest_word (digest_word)
  );

endmodule

### sv/sha256sh_checker.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Port-level checks on the digest sequence, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sha256_stream_hasher_unit_assert.svh"

module sha256sh_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_stall,
  input logic        dig_valid,
  input logic        dig_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  logic msg_acc;
  logic dig_acc;

  assign msg_acc = msg_valid & ~msg_stall;
  assign dig_acc = dig_valid & ~dig_stall;

  `SHS_ASSERT_NEXT(a_dig_hold, dig_valid && dig_stall, dig_valid && $stable(digest_word) && $stable(word_index), "stalled digest word changed")
  `SHS_ASSERT_NOW(a_last_flag, dig_valid, last_word == (word_index == 3'd7), "last_word does not match index seven")
  `SHS_ASSERT_NEXT(a_index_step, dig_acc && !last_word, dig_valid && (word_index == $past(word_index) + 3'd1), "digest word index did not advance")
  `SHS_ASSERT_NEXT(a_done, dig_acc && last_word, !dig_valid && !msg_stall, "hasher not idle after final digest word")
  `SHS_ASSERT_NOW(a_no_intake, msg_acc, !dig_valid, "input taken while digest pending")

endmodule

bind sha256_stream_hasher_unit sha256sh_checker u_chk (.*);
